FILE: sv/egbr_pkg.sv
// Shared types and constants for the exp-Golomb bit reader.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package egbr_pkg;

    localparam int BUFFER_BYTES = 4;
    localparam int BYTE_W       = 8;
    localparam int IDX_W        = 3;
    localparam int POS_W        = $clog2(BUFFER_BYTES + 1);
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 6;
    localparam int KIND_W       = 2;
    localparam int MAX_FIELD    = 32;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BIT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIELD = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UE    = 2'd3;

    // Status from the bit source toward the sequencer.
    typedef struct packed {
        logic bit_val;    // bit returned if the source advances now
        logic end_after;  // position is at the end once it has advanced
    } egbr_bit_t;

    // Finished result offered to the output register.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } egbr_res_t;

endpackage

FILE: sv/egbr_bit_src.sv
// Bit source: first buffer byte, byte position and bit index.
// Depends on egbr_pkg.
`timescale 1ns / 1ps

module egbr_bit_src
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [egbr_pkg::BYTE_W-1:0]  load_byte,
    input  logic                         advance,
    output egbr_pkg::egbr_bit_t          bit_info
);
    import egbr_pkg::*;

    logic [BYTE_W-1:0] first_byte_reg, first_byte_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [POS_W-1:0]  pos_adv;

    // Only the first byte holds data; all later bytes read as zero.
    always_comb
    begin
        if (idx_reg == '0 && pos_reg < POS_W'(BUFFER_BYTES))
        begin
            pos_adv = POS_W'(pos_reg + 1'b1);
        end
        else
        begin
            pos_adv = pos_reg;
        end
        bit_info.bit_val   = (pos_reg == '0) ? first_byte_reg[idx_reg] : 1'b0;
        bit_info.end_after = (pos_adv >= POS_W'(BUFFER_BYTES));
    end

    always_comb
    begin
        first_byte_next = first_byte_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        if (load)
        begin
            first_byte_next = load_byte;
            pos_next        = '0;
            idx_next        = '1;
        end
        else if (advance)
        begin
            pos_next = pos_adv;
            idx_next = IDX_W'(idx_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_byte_reg <= '0;
            pos_reg        <= POS_W'(BUFFER_BYTES);
            idx_reg        <= '1;
        end
        else
        begin
            first_byte_reg <= first_byte_next;
            pos_reg        <= pos_next;
            idx_reg        <= idx_next;
        end
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(BUFFER_BYTES))
        else $error("byte position beyond buffer end");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !load && pos_reg == POS_W'(BUFFER_BYTES) |=> pos_reg == POS_W'(BUFFER_BYTES))
        else $error("byte position left the end of the buffer");

    a_load_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> pos_reg == '0 && idx_reg == '1)
        else $error("load did not rewind the read position");

endmodule

FILE: sv/egbr_seq.sv
// Sequencer: decodes items, steps the bit source and shifts bits into
// the accumulator one per cycle. Depends on egbr_pkg.
`timescale 1ns / 1ps

module egbr_seq
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [egbr_pkg::KIND_W-1:0]  kind,
    input  logic [egbr_pkg::COUNT_W-1:0] bit_count,
    output logic                         in_stall,
    input  egbr_pkg::egbr_bit_t          bit_info,
    output logic                         load,
    output logic                         advance,
    input  logic                         res_free,
    output egbr_pkg::egbr_res_t          res
);
    import egbr_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_PREFIX, S_FIELD, S_FINISH} state_t;

    state_t             state_reg, state_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [COUNT_W-1:0] zeros_reg, zeros_next;
    logic               ue_reg, ue_next;
    logic               take;

    assign in_stall = (state_reg != S_IDLE);
    assign take     = in_valid && !in_stall;
    assign load     = take && (kind == KIND_LOAD);

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        zeros_next = zeros_reg;
        ue_next    = ue_reg;
        advance    = 1'b0;
        res.valid  = 1'b0;
        // ue value is ({1, field} - 1): seed the accumulator with a one
        res.value  = ue_reg ? VALUE_W'(acc_reg - 1'b1) : acc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (kind)
                        KIND_BIT:
                        begin
                            acc_next   = '0;
                            cnt_next   = COUNT_W'(1);
                            ue_next    = 1'b0;
                            state_next = S_FIELD;
                        end
                        KIND_FIELD:
                        begin
                            acc_next   = '0;
                            cnt_next   = (bit_count > COUNT_W'(MAX_FIELD))
                                         ? COUNT_W'(MAX_FIELD) : bit_count;
                            ue_next    = 1'b0;
                            state_next = S_FIELD;
                        end
                        KIND_UE:
                        begin
                            acc_next   = VALUE_W'(1);
                            zeros_next = '0;
                            ue_next    = 1'b1;
                            state_next = S_PREFIX;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PREFIX:
            begin
                // count leading zeros; stop at a one, at 32 zeros or at the end
                advance = 1'b1;
                if (!bit_info.bit_val && zeros_reg < COUNT_W'(MAX_FIELD)
                    && !bit_info.end_after)
                begin
                    zeros_next = COUNT_W'(zeros_reg + 1'b1);
                end
                else
                begin
                    cnt_next   = zeros_reg;
                    state_next = S_FIELD;
                end
            end
            S_FIELD:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    advance  = 1'b1;
                    acc_next = {acc_reg[VALUE_W-2:0], bit_info.bit_val};
                    cnt_next = COUNT_W'(cnt_reg - 1'b1);
                end
            end
            S_FINISH:
            begin
                // hold until the output register can take the word
                if (res_free)
                begin
                    res.valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            zeros_reg <= '0;
            ue_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            zeros_reg <= zeros_next;
            ue_reg    <= ue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= COUNT_W'(MAX_FIELD))
        else $error("field count above limit");

    a_zeros_range: assert property (@(posedge clk) disable iff (!rst_n)
        zeros_reg <= COUNT_W'(MAX_FIELD))
        else $error("ue prefix count above limit");

    a_finish_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && res_free |=> state_reg == S_IDLE)
        else $error("finished result not released");

endmodule

FILE: sv/exp_golomb_bit_reader.sv
// Exp-Golomb bit reader: load, single-bit, n-bit field and ue(v) reads.
// Throughput: one item at a time on a single shift path, one buffer bit per cycle;
// a finished item holds off the next one until the output register is free.
// Result sits in an output register, so the next item enters while it waits.
// Reset (rst_n, async, active low): position at buffer end, reads give zero.
`timescale 1ns / 1ps

module exp_golomb_bit_reader
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [egbr_pkg::KIND_W-1:0]  kind,
    input  logic [egbr_pkg::BYTE_W-1:0]  load_byte,
    input  logic [egbr_pkg::COUNT_W-1:0] bit_count,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [egbr_pkg::VALUE_W-1:0] value
);
    import egbr_pkg::*;

    egbr_bit_t          bit_info;
    egbr_res_t          res;
    logic               load;
    logic               advance;
    logic               res_free;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] value_reg;

    // Buffer state and the current bit.
    egbr_bit_src u_bit_src
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_byte (load_byte),
        .advance   (advance),
        .bit_info  (bit_info)
    );

    // Item decode and the serial accumulator.
    egbr_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .bit_count (bit_count),
        .in_stall  (in_stall),
        .bit_info  (bit_info),
        .load      (load),
        .advance   (advance),
        .res_free  (res_free),
        .res       (res)
    );

    // The output register is free when empty or when its word leaves now.
    assign res_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            // drop the word once taken
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the word while stalled; load a new one only when free.
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            value_reg <= res.value;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !out_valid_reg || !out_stall)
        else $error("result written over a waiting word");

    a_no_result_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !res.valid && !advance)
        else $error("load overlapped with a read");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |=> out_valid && value == $past(res.value))
        else $error("finished result not presented");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for exp_golomb_bit_reader: loads, bit, field and ue reads.
// A built-in bit-stream predictor checks every value word.
// Depends on egbr_pkg and the exp_golomb_bit_reader RTL.
`timescale 1ns / 1ps

module testbench;

    import egbr_pkg::*;

    localparam int RUN_LIMIT  = 1000000;  // cycles before the watchdog gives up
    localparam int WORD_GOAL  = 1700;     // least number of input words planned
    localparam int PAUSE_STEP = 300;      // planned words between drain pauses
    localparam int SETTLE     = 100;      // quiet cycles checked at the end

    // One planned input word, or a marker that holds the sender until drained.
    typedef struct {
        logic               pause;
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  load_byte;
        logic [COUNT_W-1:0] bit_count;
    } word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Drive every block input to a known value from time zero.
    logic                in_valid  = 1'b0;
    logic [KIND_W-1:0]   kind      = KIND_LOAD;
    logic [BYTE_W-1:0]   load_byte = '0;
    logic [COUNT_W-1:0]  bit_count = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    logic [VALUE_W-1:0]  value;

    // Flags sampled at the rising edge, read by the falling-edge drivers.
    logic tb_live  = 1'b0;
    logic in_taken = 1'b0;

    // Idle control for both sides; a calm flag gives stretches with no idling.
    int   gap_left   = 0;
    int   stall_left = 0;
    logic calm_in    = 1'b0;
    logic calm_out   = 1'b0;

    int cycle_count = 0;
    int err_count   = 0;

    // Words still to send, and values the block owes us, oldest first.
    word_t              word_plan[$];
    logic [VALUE_W-1:0] value_due[$];

    // Bit-stream predictor state: only the first byte can hold ones.
    logic [BYTE_W-1:0] bs_first_byte = '0;
    logic [POS_W-1:0]  bs_pos        = POS_W'(BUFFER_BYTES);
    logic [3:0]        bs_bits_left  = 4'd8;

    exp_golomb_bit_reader u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .load_byte (load_byte),
        .bit_count (bit_count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Consume one bit at the current position; past the end it reads as zero
    // and the byte position stays pinned at the end of the buffer.
    function automatic logic pull_bit();
        logic              b;
        logic [BYTE_W-1:0] cur;
        b = 1'b0;
        if (bs_bits_left == 4'd0 || bs_bits_left > 4'd8)
            bs_bits_left = 4'd8;
        bs_bits_left = bs_bits_left - 4'd1;
        if (bs_pos < POS_W'(BUFFER_BYTES))
        begin
            cur = (bs_pos == '0) ? bs_first_byte : '0;
            b   = cur[bs_bits_left[2:0]];
        end
        if (bs_bits_left == 4'd0)
        begin
            if (bs_pos < POS_W'(BUFFER_BYTES))
                bs_pos = bs_pos + 1'b1;
            bs_bits_left = 4'd8;
        end
        return b;
    endfunction

    // Read an MSB-first field; counts above the word width clamp to it.
    function automatic logic [VALUE_W-1:0] pull_field(input int unsigned count);
        logic [VALUE_W-1:0] acc;
        int unsigned        n;
        acc = '0;
        n   = (count > MAX_FIELD) ? MAX_FIELD : count;
        for (int unsigned i = 0; i < n; i++)
            acc = {acc[VALUE_W-2:0], pull_bit()};
        return acc;
    endfunction

    // ue(v): the first bit is always consumed; stop counting zeros at a one,
    // at 32 zeros or at the buffer end, then add 2^zeros - 1 with wrap.
    function automatic logic [VALUE_W-1:0] pull_ue();
        int unsigned zeros;
        logic [63:0] sum;
        zeros = 0;
        while (pull_bit() == 1'b0 && zeros < MAX_FIELD && bs_pos < POS_W'(BUFFER_BYTES))
            zeros++;
        sum = {32'b0, pull_field(zeros)};
        sum = sum + ((64'd1 << zeros) - 64'd1);
        return sum[VALUE_W-1:0];
    endfunction

    // Idle length: mostly short, now and then a long one.
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        err_count++;
    endtask

    task automatic plan_word(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b,
                             input logic [COUNT_W-1:0] c);
        word_t w;
        w.pause     = 1'b0;
        w.kind      = k;
        w.load_byte = b;
        w.bit_count = c;
        word_plan.push_back(w);
    endtask

    task automatic plan_pause();
        word_t w;
        w.pause     = 1'b1;
        w.kind      = KIND_LOAD;
        w.load_byte = '0;
        w.bit_count = '0;
        word_plan.push_back(w);
    endtask

    // Sender: change inputs at the falling edge only. Hold a stalled word,
    // insert gaps after accepted words, and at a pause marker hold off until
    // every expected value has come back.
    always @(negedge clk)
    begin : drive_words
        word_t w;
        if (!tb_live)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_taken)
        begin
            // stalled: hold the word as it is
        end
        else if (gap_left != 0)
        begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (word_plan.size() != 0 && word_plan[0].pause)
        begin
            in_valid <= 1'b0;
            if (value_due.size() == 0)
                word_plan.delete(0);
        end
        else if (word_plan.size() != 0)
        begin
            w = word_plan.pop_front();
            in_valid  <= 1'b1;
            kind      <= w.kind;
            load_byte <= w.load_byte;
            bit_count <= w.bit_count;
            gap_left  <= (calm_in || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        end
        else
        begin
            in_valid <= 1'b0;
        end
        if ($urandom_range(0, 99) == 0)
            calm_in <= !calm_in;
    end

    // Receiver: raise stall in runs of random length, except in calm stretches.
    always @(negedge clk)
    begin
        if (!tb_live)
        begin
            out_stall <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!calm_out && $urandom_range(0, 3) == 0)
                stall_left <= idle_len();
        end
        if ($urandom_range(0, 99) == 0)
            calm_out <= !calm_out;
    end

    // Monitor: sample both handshakes at the rising edge. Check the outgoing
    // word first, then advance the predictor with the incoming one; a value
    // never leaves in the same cycle its word enters.
    always @(posedge clk)
    begin : watch_ports
        logic [VALUE_W-1:0] want;
        cycle_count <= cycle_count + 1;
        tb_live     <= rst_n;
        in_taken    <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (value_due.size() == 0)
                begin
                    report_mismatch($sformatf("value %h with nothing expected", value));
                end
                else
                begin
                    want = value_due.pop_front();
                    if (value !== want)
                        report_mismatch($sformatf("value %h, expected %h", value, want));
                end
            end
            if (in_valid && !in_stall)
            begin
                case (kind)
                    KIND_LOAD:
                    begin
                        bs_first_byte = load_byte;
                        bs_pos        = '0;
                        bs_bits_left  = 4'd8;
                    end
                    KIND_BIT:   value_due.push_back({{(VALUE_W-1){1'b0}}, pull_bit()});
                    KIND_FIELD: value_due.push_back(pull_field(32'(bit_count)));
                    default:    value_due.push_back(pull_ue());
                endcase
            end
        end
    end

    // Watchdog: end the run if the traffic never drains.
    initial
    begin
        while (cycle_count < RUN_LIMIT)
            @(posedge clk);
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned planned;
        int unsigned next_pause;
        int unsigned reads;
        planned    = 0;
        next_pause = PAUSE_STEP;

        // Directed: reads before any load return zero.
        plan_word(KIND_BIT,   8'h00, 6'd0);
        plan_word(KIND_FIELD, 8'hFF, 6'd13);
        plan_word(KIND_UE,    8'h00, 6'd0);
        // All ones, then run off the first byte into the cleared ones.
        plan_word(KIND_LOAD,  8'hFF, 6'd0);
        plan_word(KIND_BIT,   8'h00, 6'd0);
        plan_word(KIND_FIELD, 8'h00, 6'd7);
        plan_word(KIND_FIELD, 8'h00, 6'd3);
        // Zero byte: the ue prefix runs until the buffer ends.
        plan_word(KIND_LOAD,  8'h00, 6'd0);
        plan_word(KIND_UE,    8'h00, 6'd0);
        // Leading one gives code zero; the next code reads only zero bits.
        plan_word(KIND_LOAD,  8'h80, 6'd0);
        plan_word(KIND_UE,    8'h00, 6'd0);
        plan_word(KIND_UE,    8'h00, 6'd0);
        // Seven zeros, then a suffix taken from the cleared bytes; then two zeros and a suffix from the first byte.
        plan_word(KIND_LOAD,  8'h01, 6'd0);
        plan_word(KIND_UE,    8'h00, 6'd0);
        plan_word(KIND_LOAD,  8'h3F, 6'd0);
        plan_word(KIND_UE,    8'h00, 6'd0);
        // Zero count consumes nothing; a count above 32 clamps.
        plan_word(KIND_LOAD,  8'h5A, 6'd0);
        plan_word(KIND_FIELD, 8'h00, 6'd0);
        plan_word(KIND_FIELD, 8'h00, 6'd63);
        plan_word(KIND_LOAD,  8'hA5, 6'd63);
        plan_word(KIND_FIELD, 8'hFF, 6'd32);
        plan_word(KIND_BIT,   8'hFF, 6'd63);
        plan_word(KIND_LOAD,  8'hC3, 6'd63);
        plan_word(KIND_FIELD, 8'h00, 6'd33);
        plan_pause();
        planned = word_plan.size() - 1;

        // Random: mostly a load followed by a short run of reads, with some
        // lone words of any kind mixed in as noise.
        while (planned < WORD_GOAL)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                plan_word(KIND_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                          COUNT_W'($urandom_range(0, 63)));
                planned++;
            end
            else
            begin
                plan_word(KIND_LOAD,
                          BYTE_W'($urandom_range(0, 255) >> $urandom_range(0, 8)),
                          COUNT_W'($urandom_range(0, 63)));
                reads = $urandom_range(1, 6);
                for (int unsigned i = 0; i < reads; i++)
                    plan_word(KIND_W'($urandom_range(1, 3)),
                              BYTE_W'($urandom_range(0, 255)),
                              COUNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                                   : $urandom_range(0, 10)));
                planned += reads + 1;
            end
            if (planned >= next_pause)
            begin
                plan_pause();
                next_pause += PAUSE_STEP;
            end
        end

        // Hold reset, then release it at a falling edge.
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Wait for the last word to go in (the sender moves on falling edges),
        // then for the last value to come out (the monitor moves on rising ones).
        while (word_plan.size() != 0 || in_valid)
            @(posedge clk);
        @(negedge clk);
        while (value_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

FILE: files.f
sv/egbr_pkg.sv
sv/egbr_bit_src.sv
sv/egbr_seq.sv
sv/exp_golomb_bit_reader.sv
tb/testbench.sv
